// ----- hdl/assert_macros.svh -----
// Assertion macros for the file that carries concurrent checks, the top level.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge outside of reset.
`define QC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) else $error(msg);

// Checks that a condition implies another one in the same cycle.
`define QC_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// ----- hdl/qcse_pkg.sv -----
// Types and constants of the quadrature count speed estimator.
`timescale 1ns / 1ps

package qcse_pkg;

  localparam int NUM_BITS = 51;
  localparam int DEN_W    = 36;

  localparam logic [19:0] US_PER_S   = 20'd1000000;
  localparam logic [30:0] RPM_COEF   = 31'd60;
  localparam logic [30:0] TWO_PI_Q28 = 31'd1686629713;

  localparam logic CFG_CPR  = 1'b0;
  localparam logic CFG_MODE = 1'b1;

  typedef struct packed {
    logic step;
    logic qbit;
    logic done;
  } qcse_qbit_t;

endpackage

// ----- hdl/quadrature_count_speed_estimator.sv -----
// Top level of the quadrature count speed estimator with its sequencer.
// A speed sample passes from its input transfer through the delta, multiply, divide,
// sign and finish states, the restoring divider resolving one quotient bit per cycle
// over 51 + FRAC_BITS steps; a clear or a zero-time sample goes from the delta state
// straight to the finish state. One item is worked on at a time, and the next input
// transfer is taken as soon as the result sits in the output register.
`timescale 1ns / 1ps

module quadrature_count_speed_estimator #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic               cfg_idx_i,
  input  logic [15:0]        cfg_data_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic               kind_i,
  input  logic [31:0]        counter_value_i,
  input  logic [19:0]        elapsed_us_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] tick_delta_o,
  output logic signed [31:0] tick_total_o,
  output logic signed [31:0] speed_rpm_o,
  output logic signed [31:0] speed_rad_o,
  output logic               updated_o
);
  import qcse_pkg::*;

  `include "assert_macros.svh"

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_DELTA = 3'd1;
  localparam logic [2:0] S_MUL   = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SIGN  = 3'd4;
  localparam logic [2:0] S_FIN   = 3'd5;

  logic [2:0]  state_q, state_d;
  logic [15:0] cpr_q;
  logic        mode16_q;
  logic [31:0] prev_q, total_q, rpm_q, rad_q;
  logic        kind_q;
  logic [31:0] cur_q;
  logic [19:0] us_q;
  logic [31:0] delta_q, mag_q;
  logic        neg_q, upd_q, mag_zero_q, den_zero_q;
  logic        out_valid_q;

  logic [31:0]           diff;
  logic [31:0]           delta_w;
  logic [NUM_BITS-1:0]   num_full;
  logic [DEN_W-1:0]      den_w;
  logic                  start;
  qcse_qbit_t            qb;
  logic [31:0]           rpm_mag, rad_mag;
  logic [31:0]           rpm_sel, rad_sel;
  logic                  out_free;

  function automatic logic [31:0] apply_sign(input logic [31:0] mag, input logic neg);
    logic [31:0] res;
    if (neg) begin
      res = 32'd0 - mag;
    end else if (mag[31]) begin
      res = 32'h7FFF_FFFF;
    end else begin
      res = mag;
    end
    return res;
  endfunction

  assign diff     = cur_q - prev_q;
  assign delta_w  = mode16_q ? {{16{diff[15]}}, diff[15:0]} : diff;
  assign num_full = NUM_BITS'(mag_q) * NUM_BITS'(US_PER_S);
  assign den_w    = DEN_W'(cpr_q) * DEN_W'(us_q);
  assign start    = state_q == S_MUL;
  assign out_free = !out_valid_q || !out_stall_i;

  assign rpm_sel = mag_zero_q ? 32'd0 : (den_zero_q ? 32'h8000_0000 : rpm_mag);
  assign rad_sel = mag_zero_q ? 32'd0 : (den_zero_q ? 32'h8000_0000 : rad_mag);

  assign in_stall_o  = state_q != S_IDLE;
  assign out_valid_o = out_valid_q;

  qcse_divider #(
    .FRAC_BITS(FRAC_BITS)
  ) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .num_i  (num_full),
    .den_i  (den_w),
    .qb_o   (qb)
  );

  qcse_speed_acc #(
    .SHIFT(FRAC_BITS - 8),
    .COEF (RPM_COEF)
  ) u_rpm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .qb_i   (qb),
    .mag_o  (rpm_mag)
  );

  qcse_speed_acc #(
    .SHIFT(FRAC_BITS + 18),
    .COEF (TWO_PI_Q28)
  ) u_rad (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .qb_i   (qb),
    .mag_o  (rad_mag)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_IDLE:  if (in_valid_i) state_d = S_DELTA;
      S_DELTA: begin
        if (kind_q || (us_q == 20'd0)) begin
          state_d = S_FIN;
        end else begin
          state_d = S_MUL;
        end
      end
      S_MUL:   state_d = S_DIV;
      S_DIV:   if (qb.done) state_d = S_SIGN;
      S_SIGN:  state_d = S_FIN;
      S_FIN:   if (out_free) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cpr_q       <= 16'd1024;
      mode16_q    <= 1'b1;
      prev_q      <= '0;
      total_q     <= '0;
      rpm_q       <= '0;
      rad_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          CFG_CPR:  cpr_q    <= cfg_data_i;
          CFG_MODE: mode16_q <= cfg_data_i[0];
          default:  ;
        endcase
      end
      if (state_q == S_DELTA) begin
        if (kind_q) begin
          prev_q  <= cur_q;
          total_q <= '0;
          rpm_q   <= '0;
          rad_q   <= '0;
        end else if (us_q != 20'd0) begin
          prev_q  <= cur_q;
          total_q <= total_q + delta_w;
        end
      end
      if (state_q == S_SIGN) begin
        rpm_q <= apply_sign(rpm_sel, neg_q);
        rad_q <= apply_sign(rad_sel, neg_q);
      end
      if ((state_q == S_FIN) && out_free) begin
        out_valid_q <= 1'b1;
      end else if (!out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if ((state_q == S_IDLE) && in_valid_i) begin
      kind_q <= kind_i;
      cur_q  <= counter_value_i;
      us_q   <= elapsed_us_i;
    end
    if (state_q == S_DELTA) begin
      if (kind_q || (us_q == 20'd0)) begin
        delta_q <= '0;
        upd_q   <= kind_q;
      end else begin
        delta_q <= delta_w;
        upd_q   <= 1'b1;
        neg_q   <= delta_w[31];
        mag_q   <= delta_w[31] ? (32'd0 - delta_w) : delta_w;
      end
    end
    if (state_q == S_MUL) begin
      mag_zero_q <= mag_q == 32'd0;
      den_zero_q <= den_w == '0;
    end
    if ((state_q == S_FIN) && out_free) begin
      tick_delta_o <= $signed(delta_q);
      tick_total_o <= $signed(total_q);
      speed_rpm_o  <= $signed(rpm_q);
      speed_rad_o  <= $signed(rad_q);
      updated_o    <= upd_q;
    end
  end

  `QC_ASSERT_IMPL(a_done_in_div, qb.done, state_q == S_DIV, "divider finished outside divide")
  `QC_ASSERT_IMPL(a_out_from_fin, $rose(out_valid_q), $past(state_q) == S_FIN,
                  "result appeared without a finishing step")
  `QC_ASSERT_IMPL(a_skip_no_delta, out_valid_o && !updated_o, tick_delta_o == 32'sd0,
                  "skipped sample reported a nonzero delta")
  `QC_ASSERT(a_idle_div, (state_q == S_IDLE) |-> !qb.step, "divider running while idle")

endmodule

// ----- hdl/qcse_divider.sv -----
// Restoring divider that produces one quotient bit per cycle, MSB first.
`timescale 1ns / 1ps

module qcse_divider #(
  parameter int FRAC_BITS = 16
) (
  input  logic                             clk_i,
  input  logic                             rst_ni,
  input  logic                             start_i,
  input  logic [qcse_pkg::NUM_BITS-1:0]    num_i,
  input  logic [qcse_pkg::DEN_W-1:0]       den_i,
  output qcse_pkg::qcse_qbit_t             qb_o
);
  import qcse_pkg::*;

  localparam int NUM_STEPS = NUM_BITS + FRAC_BITS;
  localparam int CW        = $clog2(NUM_STEPS);

  logic                run_q;
  logic [CW-1:0]       cnt_q;
  logic [NUM_BITS-1:0] num_q;
  logic [DEN_W-1:0]    den_q;
  logic [DEN_W-1:0]    rem_q;
  logic [DEN_W:0]      rem_sh;
  logic [DEN_W-1:0]    rem_sub;
  logic                ge;
  logic                last;

  assign rem_sh  = {rem_q, num_q[NUM_BITS-1]};
  assign ge      = rem_sh >= {1'b0, den_q};
  assign rem_sub = ge ? DEN_W'(rem_sh - {1'b0, den_q}) : rem_sh[DEN_W-1:0];
  assign last    = cnt_q == CW'(NUM_STEPS - 1);

  assign qb_o.step = run_q;
  assign qb_o.qbit = ge;
  assign qb_o.done = run_q && last;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      run_q <= 1'b0;
      cnt_q <= '0;
    end else if (start_i) begin
      run_q <= 1'b1;
      cnt_q <= '0;
    end else if (run_q) begin
      cnt_q <= cnt_q + CW'(1);
      if (last) begin
        run_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      num_q <= num_i;
      den_q <= den_i;
      rem_q <= '0;
    end else if (run_q) begin
      num_q <= {num_q[NUM_BITS-2:0], 1'b0};
      rem_q <= rem_sub;
    end
  end

endmodule

// ----- hdl/qcse_speed_acc.sv -----
// Saturating Horner accumulator that scales the serial quotient by a constant.
`timescale 1ns / 1ps

module qcse_speed_acc #(
  parameter int          SHIFT = 8,
  parameter logic [30:0] COEF  = 31'd60
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 start_i,
  input  qcse_pkg::qcse_qbit_t qb_i,
  output logic [31:0]          mag_o
);
  import qcse_pkg::*;

  localparam int             AW      = SHIFT + 34;
  localparam logic [AW-1:0]  COEF_W  = AW'(COEF);
  localparam logic [AW-1:0]  SAT_LIM = AW'(32'h8000_0001) << SHIFT;

  logic [AW-1:0] acc_q;
  logic [AW-1:0] sum;
  logic          sat_q;

  assign sum   = {acc_q[AW-2:0], 1'b0} + (qb_i.qbit ? COEF_W : '0);
  assign mag_o = sat_q ? 32'h8000_0000 : acc_q[SHIFT +: 32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sat_q <= 1'b0;
    end else if (start_i) begin
      sat_q <= 1'b0;
    end else if (qb_i.step && !sat_q && (sum >= SAT_LIM)) begin
      sat_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      acc_q <= '0;
    end else if (qb_i.step && !sat_q) begin
      acc_q <= sum;
    end
  end

endmodule
